### rtl/core/psg_pkg.sv
// Shared types, register codes and fixed-point constants for the PSG block.
package psg_pkg;

  // Register file geometry
  localparam int NUM_REGS   = 16;
  localparam int REG_IDX_W  = 4;
  localparam int REG_W      = 8;
  localparam int NUM_VOICES = 3;

  // Generator state widths
  localparam int TONE_W  = 12;
  localparam int NOISE_W = 5;
  localparam int LFSR_W  = 17;
  localparam int ENV_W   = 16;
  localparam int STEP_W  = 5;
  localparam int SHAPE_W = 4;
  localparam int MIXER_W = 6;
  localparam int VOL_W   = 5;

  localparam logic [STEP_W-1:0] STEP_MAX = 5'd31;

  // Item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TONE0_LO = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_TONE0_HI = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_TONE1_LO = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_TONE1_HI = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_TONE2_LO = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_TONE2_HI = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_NOISE    = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_MIXER    = 4'd7;
  localparam logic [REG_IDX_W-1:0] REG_VOL0     = 4'd8;
  localparam logic [REG_IDX_W-1:0] REG_VOL1     = 4'd9;
  localparam logic [REG_IDX_W-1:0] REG_VOL2     = 4'd10;
  localparam logic [REG_IDX_W-1:0] REG_ENV_LO   = 4'd11;
  localparam logic [REG_IDX_W-1:0] REG_ENV_HI   = 4'd12;
  localparam logic [REG_IDX_W-1:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [REG_IDX_W-1:0] REG_IO_A     = 4'd14;  // stored only
  localparam logic [REG_IDX_W-1:0] REG_IO_B     = 4'd15;  // stored only

  // Envelope shape bit positions
  localparam int SHAPE_HOLD   = 0;
  localparam int SHAPE_ALT    = 1;
  localparam int SHAPE_ATTACK = 2;
  localparam int SHAPE_CONT   = 3;

  // Envelope heading
  typedef logic signed [1:0] head_t;
  localparam head_t HEAD_UP   = 2'sb01;
  localparam head_t HEAD_DOWN = 2'sb11;
  localparam head_t HEAD_STOP = 2'sb00;

  // Snapshot of everything the mixer needs for one tick
  typedef struct packed {
    logic [NUM_VOICES-1:0]            tone_lvl;
    logic                             noise_bit;
    logic [MIXER_W-1:0]               mixer;
    logic [NUM_VOICES-1:0][VOL_W-1:0] vol;
    logic [STEP_W-1:0]                env_step;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t tick;
  } tick_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Tick queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Mixer arithmetic
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int NUM_LANES = 2;
  localparam int LANE_L    = 0;
  localparam int LANE_R    = 1;
  localparam int AMP_W     = 9;   // amplitude up to 465
  localparam int VOICE_W   = 11;  // signed voice term up to +/-465
  localparam int MIX_W     = 14;  // signed lane sum up to +/-7905
  localparam int MAG_W     = 13;
  typedef logic signed [VOICE_W-1:0] voice_t;
  typedef logic signed [MIX_W-1:0]   mix_t;
  localparam mix_t GAIN_SIDE = 14'sd10;
  localparam mix_t GAIN_MID  = 14'sd7;

  // sample = round(mag * 2^SAMPLE_BITS / DEN), ties away from zero
  localparam int DEN      = 23250;
  localparam int DEN_W    = 15;
  localparam int HALF_DEN = DEN / 2;
  localparam int Y_W      = 28;   // mag * rem + half stays below 2^28
  localparam int RECIP_SHIFT = 43;
  localparam int RECIP_W  = 29;
  localparam int PROD_W   = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));

endpackage

### rtl/core/psg_front.sv
// Front end: register file, tone/noise/envelope generators, tick snapshots.
module psg_front import psg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_action,
  input  logic [REG_IDX_W-1:0] in_reg_index,
  input  logic [REG_W-1:0]     in_reg_value,
  output tick_push_t           push_o
);

  logic [REG_W-1:0]      rf_r [NUM_REGS];
  logic [REG_W-1:0]      rf_nxt [NUM_REGS];
  logic [TONE_W-1:0]     tone_div_r [NUM_VOICES];
  logic [TONE_W-1:0]     tone_div_nxt [NUM_VOICES];
  logic [TONE_W-1:0]     tone_cnt_r [NUM_VOICES];
  logic [TONE_W-1:0]     tone_cnt_nxt [NUM_VOICES];
  logic [NUM_VOICES-1:0] tone_lvl_r, tone_lvl_nxt;
  logic [NOISE_W-1:0]    noise_div_r, noise_div_nxt;
  logic [NOISE_W-1:0]    noise_cnt_r, noise_cnt_nxt;
  logic [LFSR_W-1:0]     lfsr_r, lfsr_nxt;
  logic [ENV_W-1:0]      env_div_r, env_div_nxt;
  logic [ENV_W-1:0]      env_cnt_r, env_cnt_nxt;
  logic [STEP_W-1:0]     env_step_r, env_step_nxt;
  head_t                 env_head_r, env_head_nxt;
  logic [SHAPE_W-1:0]    env_shape_r, env_shape_nxt;

  logic [TONE_W:0]       tone_sum [NUM_VOICES];
  logic [NOISE_W:0]      noise_sum;
  logic [ENV_W:0]        env_sum;
  logic signed [STEP_W+1:0] step_try;
  logic [STEP_W-1:0]     step_clamp;
  head_t                 head_rev;
  logic [1:0]            wr_ch;
  logic [TONE_W-1:0]     tone_hi;
  logic [ENV_W-1:0]      env_hi;
  logic                  do_tick, do_write;

  // Next state: a tick advances the generators, a changed byte updates the registers
  always_comb begin
    rf_nxt        = rf_r;
    tone_div_nxt  = tone_div_r;
    tone_cnt_nxt  = tone_cnt_r;
    tone_lvl_nxt  = tone_lvl_r;
    noise_div_nxt = noise_div_r;
    noise_cnt_nxt = noise_cnt_r;
    lfsr_nxt      = lfsr_r;
    env_div_nxt   = env_div_r;
    env_cnt_nxt   = env_cnt_r;
    env_step_nxt  = env_step_r;
    env_head_nxt  = env_head_r;
    env_shape_nxt = env_shape_r;

    do_tick  = in_fire && (in_action == ACT_TICK);
    do_write = in_fire && (in_action == ACT_WRITE) && (rf_r[in_reg_index] != in_reg_value);
    wr_ch    = in_reg_index[2:1];
    tone_hi  = '0;
    env_hi   = {in_reg_value, env_div_r[7:0]};

    for (int i = 0; i < NUM_VOICES; i++) begin
      tone_sum[i] = {1'b0, tone_cnt_r[i]} + (TONE_W+1)'(1);
    end
    noise_sum  = {1'b0, noise_cnt_r} + (NOISE_W+1)'(1);
    env_sum    = {1'b0, env_cnt_r} + (ENV_W+1)'(1);
    step_try   = $signed({2'b00, env_step_r}) + (STEP_W+2)'(env_head_r);
    step_clamp = step_try[STEP_W+1] ? '0 : STEP_MAX;
    head_rev   = -env_head_r;

    if (do_tick) begin
      // tone dividers
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (tone_sum[i] >= {1'b0, tone_div_r[i]}) begin
          tone_cnt_nxt[i] = '0;
          tone_lvl_nxt[i] = ~tone_lvl_r[i];
        end else begin
          tone_cnt_nxt[i] = tone_sum[i][TONE_W-1:0];
        end
      end
      // noise divider and LFSR
      if (noise_sum >= {1'b0, noise_div_r}) begin
        noise_cnt_nxt = '0;
        lfsr_nxt = {~(lfsr_r[0] ^ lfsr_r[3]), lfsr_r[LFSR_W-1:1]};
      end else begin
        noise_cnt_nxt = noise_sum[NOISE_W-1:0];
      end
      // envelope stepping with end-of-ramp rules
      if (env_sum >= {1'b0, env_div_r}) begin
        env_cnt_nxt = '0;
        if (step_try < 0 || step_try > $signed({2'b00, STEP_MAX})) begin
          if (!env_shape_r[SHAPE_CONT]) begin
            env_head_nxt = HEAD_STOP;
            env_step_nxt = step_clamp;
          end else if (env_shape_r[SHAPE_ALT]) begin
            env_head_nxt = head_rev;
            env_step_nxt = STEP_W'($signed({2'b00, step_clamp}) + (STEP_W+2)'(head_rev));
          end else begin
            env_step_nxt = env_shape_r[SHAPE_ATTACK] ? '0 : STEP_MAX;
          end
          if (env_shape_r[SHAPE_HOLD]) begin
            env_head_nxt = HEAD_STOP;
          end
        end else begin
          env_step_nxt = step_try[STEP_W-1:0];
        end
      end else begin
        env_cnt_nxt = env_sum[ENV_W-1:0];
      end
    end else if (do_write) begin
      rf_nxt[in_reg_index] = in_reg_value;
      unique case (in_reg_index) inside
        REG_TONE0_LO, REG_TONE1_LO, REG_TONE2_LO: begin
          tone_div_nxt[wr_ch] = {tone_div_r[wr_ch][TONE_W-1:8], in_reg_value};
        end
        REG_TONE0_HI, REG_TONE1_HI, REG_TONE2_HI: begin
          tone_hi = {in_reg_value[3:0], tone_div_r[wr_ch][7:0]};
          tone_div_nxt[wr_ch] = (tone_hi == '0) ? TONE_W'(1) : tone_hi;
        end
        REG_NOISE: begin
          noise_div_nxt = (in_reg_value[NOISE_W-1:0] == '0) ? NOISE_W'(1)
                                                             : in_reg_value[NOISE_W-1:0];
        end
        REG_ENV_LO: begin
          env_div_nxt = {env_div_r[ENV_W-1:8], in_reg_value};
        end
        REG_ENV_HI: begin
          env_div_nxt = (env_hi == '0) ? ENV_W'(1) : env_hi;
        end
        REG_ENV_SHAPE: begin
          env_shape_nxt = in_reg_value[SHAPE_W-1:0];
          env_step_nxt  = in_reg_value[SHAPE_ATTACK] ? '0 : STEP_MAX;
          env_head_nxt  = in_reg_value[SHAPE_ATTACK] ? HEAD_UP : HEAD_DOWN;
          env_cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Tick snapshot goes to the queue in the accept cycle
  always_comb begin
    push_o.valid          = do_tick;
    push_o.tick.tone_lvl  = tone_lvl_nxt;
    push_o.tick.noise_bit = lfsr_nxt[0];
    push_o.tick.mixer     = rf_r[REG_MIXER][MIXER_W-1:0];
    push_o.tick.vol[0]    = rf_r[REG_VOL0][VOL_W-1:0];
    push_o.tick.vol[1]    = rf_r[REG_VOL1][VOL_W-1:0];
    push_o.tick.vol[2]    = rf_r[REG_VOL2][VOL_W-1:0];
    push_o.tick.env_step  = env_step_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
        tone_div_r[i] <= TONE_W'(1);
        tone_cnt_r[i] <= '0;
      end
      tone_lvl_r  <= '1;
      noise_div_r <= NOISE_W'(1);
      noise_cnt_r <= '0;
      lfsr_r      <= LFSR_W'(1);
      env_div_r   <= ENV_W'(1);
      env_cnt_r   <= '0;
      env_step_r  <= '0;
      env_head_r  <= HEAD_DOWN;
      env_shape_r <= '0;
    end else begin
      rf_r        <= rf_nxt;
      tone_div_r  <= tone_div_nxt;
      tone_cnt_r  <= tone_cnt_nxt;
      tone_lvl_r  <= tone_lvl_nxt;
      noise_div_r <= noise_div_nxt;
      noise_cnt_r <= noise_cnt_nxt;
      lfsr_r      <= lfsr_nxt;
      env_div_r   <= env_div_nxt;
      env_cnt_r   <= env_cnt_nxt;
      env_step_r  <= env_step_nxt;
      env_head_r  <= env_head_nxt;
      env_shape_r <= env_shape_nxt;
    end
  end

endmodule

### rtl/core/psg_tick_fifo.sv
// Short queue of tick snapshots between the generators and the mixer.
module psg_tick_fifo import psg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tick_push_t push_i,
  input  logic       pop_i,
  output fifo_stat_t stat_o,
  output tick_t      head_o
);

  tick_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      mem_r[wr_ptr_r] <= push_i.tick;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push_i.valid, pop_i})
        2'b10:   count_r <= count_r + (FIFO_AW+1)'(1);
        2'b01:   count_r <= count_r - (FIFO_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign stat_o.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (count_r == '0);
  assign head_o       = mem_r[rd_ptr_r];

endmodule

### rtl/core/psg_mix_back.sv
// Back end: voice mixing, stereo panning and fixed-point scaling pipeline.
module psg_mix_back import psg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fifo_stat_t                    stat_i,
  input  tick_t                         head_i,
  output logic                          pop_o,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [SAMPLE_BITS-1:0] out_right_sample
);

  // 2^SAMPLE_BITS = QD * DEN + RD
  localparam logic [SAMPLE_BITS-1:0] QD =
    SAMPLE_BITS'((64'd1 << SAMPLE_BITS) / 64'(DEN));
  localparam logic [DEN_W-1:0] RD =
    DEN_W'((64'd1 << SAMPLE_BITS) % 64'(DEN));

  // Signed voice term: +/- amplitude, or zero when tone and noise cancel or both are off
  function automatic voice_t voice_val(input logic tone_off, input logic noise_off,
                                       input logic tone_lvl, input logic noise_bit,
                                       input logic [VOL_W-1:0] vol,
                                       input logic [STEP_W-1:0] step);
    logic [AMP_W-1:0] amp;
    logic nz, neg;
    if (vol[VOL_W-1]) begin
      amp = (AMP_W'(step) << 4) - AMP_W'(step);
    end else begin
      amp = (AMP_W'(vol[VOL_W-2:0]) << 5) - AMP_W'(vol[VOL_W-2:0]);
    end
    if (!tone_off && !noise_off) begin
      nz  = (tone_lvl == noise_bit);
      neg = !tone_lvl;
    end else if (!tone_off) begin
      nz  = 1'b1;
      neg = !tone_lvl;
    end else if (!noise_off) begin
      nz  = 1'b1;
      neg = !noise_bit;
    end else begin
      nz  = 1'b0;
      neg = 1'b0;
    end
    if (!nz) begin
      voice_val = '0;
    end else if (neg) begin
      voice_val = -$signed({2'b00, amp});
    end else begin
      voice_val = $signed({2'b00, amp});
    end
  endfunction

  logic en;
  voice_t voice [NUM_VOICES];
  mix_t   mix [NUM_LANES];

  logic                   s1_v_r, s2_v_r, s3_v_r;
  logic                   s1_neg_r [NUM_LANES];
  logic [MAG_W-1:0]       s1_mag_r [NUM_LANES];
  logic                   s2_neg_r [NUM_LANES];
  logic [Y_W-1:0]         s2_y_r [NUM_LANES];
  logic [SAMPLE_BITS-1:0] s2_p_r [NUM_LANES];
  logic                   s3_neg_r [NUM_LANES];
  logic [SAMPLE_BITS-1:0] s3_p_r [NUM_LANES];
  logic [MAG_W-1:0]       s3_q_r [NUM_LANES];
  logic                   out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_smp_r [NUM_LANES];

  logic [MAG_W+SAMPLE_BITS-1:0] p_full [NUM_LANES];
  logic [PROD_W-1:0]            z_full [NUM_LANES];
  logic [SAMPLE_BITS-1:0]       q_sum [NUM_LANES];

  // Whole pipe advances when the output register can take a new item
  assign en    = !out_valid_r || out_ready;
  assign pop_o = en && !stat_i.empty;

  // Stage 1 math: voices and panned lane sums
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice[i] = voice_val(head_i.mixer[i], head_i.mixer[i+NUM_VOICES],
                           head_i.tone_lvl[i], head_i.noise_bit,
                           head_i.vol[i], head_i.env_step);
    end
    mix[LANE_L] = GAIN_SIDE * MIX_W'(voice[0]) + GAIN_MID * MIX_W'(voice[1]);
    mix[LANE_R] = GAIN_MID * MIX_W'(voice[1]) + GAIN_SIDE * MIX_W'(voice[2]);
  end

  // Stage 2, 3 and output math: split the scale into whole and remainder parts, then add them
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      p_full[k] = (MAG_W+SAMPLE_BITS)'(s1_mag_r[k]) * (MAG_W+SAMPLE_BITS)'(QD);
      z_full[k] = PROD_W'(s2_y_r[k]) * PROD_W'(RECIP);
      q_sum[k]  = s3_p_r[k] + SAMPLE_BITS'(s3_q_r[k]);
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= !stat_i.empty;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s1_neg_r[k]  <= mix[k][MIX_W-1];
        s1_mag_r[k]  <= MAG_W'(mix[k][MIX_W-1] ? -mix[k] : mix[k]);
        s2_neg_r[k]  <= s1_neg_r[k];
        s2_y_r[k]    <= Y_W'(s1_mag_r[k]) * Y_W'(RD) + Y_W'(HALF_DEN);
        s2_p_r[k]    <= p_full[k][SAMPLE_BITS-1:0];
        s3_neg_r[k]  <= s2_neg_r[k];
        s3_p_r[k]    <= s2_p_r[k];
        s3_q_r[k]    <= z_full[k][RECIP_SHIFT +: MAG_W];
        // magnitude stays below 0.7 of full scale, so no saturation
        out_smp_r[k] <= s3_neg_r[k] ? -$signed(q_sum[k]) : $signed(q_sum[k]);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_smp_r[LANE_L];
  assign out_right_sample = out_smp_r[LANE_R];

endmodule

### rtl/core/psg_tone_noise_envelope_generator_top.sv
// Top level of the three-voice tone/noise/envelope sound generator.
// Throughput: one item per cycle while in_ready is high; a register write gives no result.
// A tick's stereo sample reaches out_valid through these registers in order:
// queue, mix, two scaling multiplies, output register.
// in_ready drops only when the 4-entry tick queue is full behind a stalled output.
// Synchronous active-low reset loads power-on generator values and empties the queue.
module psg_tone_noise_envelope_generator_top import psg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [REG_IDX_W-1:0]          in_reg_index,
  input  logic [REG_W-1:0]              in_reg_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [SAMPLE_BITS-1:0] out_right_sample
);

  tick_push_t push;
  fifo_stat_t stat;
  tick_t      head;
  logic       pop;
  logic       in_fire;

  assign in_ready = !stat.full;
  assign in_fire  = in_valid && in_ready;

  psg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_action    (in_action),
    .in_reg_index (in_reg_index),
    .in_reg_value (in_reg_value),
    .push_o       (push)
  );

  psg_tick_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (stat),
    .head_o (head)
  );

  psg_mix_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .stat_i           (stat),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample)
  );

endmodule

### rtl/core/psg_checker.sv
// Port-level assertions for the sound generator, bound to the top level.
module psg_checker import psg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_left_sample,
  input logic signed [SAMPLE_BITS-1:0] out_right_sample
);

  // Reset leaves no result pending
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Reset empties the tick queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_sample)
                                && $stable(out_right_sample))
    else $error("result changed while stalled");

  // With the output draining, the queue cannot stay full
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_ready) |-> in_ready)
    else $error("input blocked although output drained");

endmodule

bind psg_tone_noise_envelope_generator_top psg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_psg_checker (.*);
